>>> rtl/core/framed_uart_reply_receiver_unit_assert.svh
// assertion macros for the framed uart reply receiver
// expects clk and rst in the scope of the module that uses them
`ifndef FRAMED_UART_REPLY_RECEIVER_UNIT_ASSERT_SVH
`define FRAMED_UART_REPLY_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FUR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FUR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/fur_pkg.sv
// shared types and constants of the framed uart reply receiver
// no dependencies; used by the interfaces, the ram wrapper users and the top level
package fur_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] len6_t;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_HEAD = 1'd0;
  localparam cfg_index_t REG_TAIL = 1'd1;

  localparam byte_t HEAD_RESET = 8'hC5;
  localparam byte_t TAIL_RESET = 8'h5C;

  // parameter defaults
  localparam int DEF_BUFFER_BYTES = 64;
  localparam int DEF_CHANNELS     = 2;

  // frame layout
  localparam int MIN_FRAME      = 6;
  localparam int FRAME_OVERHEAD = 5;
  localparam int PAYLOAD_START  = 3;

endpackage

>>> rtl/core/fur_in_if.sv
// valid/ready channel carrying received bytes tagged with a channel
// depends on fur_pkg
interface fur_in_if;
  import fur_pkg::*;

  logic  valid;
  logic  ready;
  logic  channel;
  byte_t rx_byte;

  modport source (output valid, output channel, output rx_byte, input ready);
  modport sink   (input valid, input channel, input rx_byte, output ready);
endinterface

>>> rtl/core/fur_out_if.sv
// valid/ready channel carrying one payload byte of an accepted frame
// depends on fur_pkg
interface fur_out_if;
  import fur_pkg::*;

  logic  valid;
  logic  ready;
  logic  out_channel;
  byte_t dev_addr;
  byte_t op_code;
  byte_t status_code;
  len6_t payload_len;
  len6_t byte_index;
  byte_t payload_byte;
  byte_t frame_checksum;
  logic  last;

  modport source (
    output valid, output out_channel, output dev_addr, output op_code,
    output status_code, output payload_len, output byte_index, output payload_byte,
    output frame_checksum, output last, input ready
  );
  modport sink (
    input valid, input out_channel, input dev_addr, input op_code,
    input status_code, input payload_len, input byte_index, input payload_byte,
    input frame_checksum, input last, output ready
  );
endinterface

>>> rtl/core/framed_uart_reply_receiver_unit.sv
// framed uart reply receiver: the top level
// depends on fur_pkg, fur_in_if, fur_out_if, fur_ram and the assertion header
//
// Usage: bytes carries one received byte per transaction, tagged with a
// channel (a channel value not below CHANNELS counts as channel 0). Each
// channel hunts for the head byte and collects its frame in its own region
// of one frame ram; fill count, running sum and last byte per channel sit in
// flip-flops. A tail byte on a frame of six or more bytes whose checksum byte
// matches the 8-bit sum of all bytes before it starts a run on frames: one
// transaction per payload byte, last set on the final one.
// Throughput: one byte per cycle while no run is in progress. An accepted
// frame with N payload bytes holds bytes off while its results go out,
// because each result needs one ram read (S_READ) and then a state that
// registers its data (S_WAIT). After the tail byte is accepted, the first
// result goes through S_READ and S_WAIT before it is valid on frames.
// A stalled frames side holds the output register and the run waits for it;
// bytes stays off until the last result of the run is in the output register.
// Reset clears every fill count (all channels hunting), empties the output
// register and loads the head and tail registers with their defaults. The
// frame ram is not cleared; no byte is read before it is written.
// cfg_we writes head_byte (index 0) or tail_byte (index 1); write only idle.
module framed_uart_reply_receiver_unit #(
  parameter int BUFFER_BYTES = fur_pkg::DEF_BUFFER_BYTES,
  parameter int CHANNELS     = fur_pkg::DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  fur_in_if.sink              bytes,
  fur_out_if.source           frames,
  input  logic                cfg_we,
  input  fur_pkg::cfg_index_t cfg_index,
  input  fur_pkg::cfg_data_t  cfg_data
);
  import fur_pkg::*;

  `include "framed_uart_reply_receiver_unit_assert.svh"

  localparam int DEPTH  = CHANNELS * BUFFER_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state;
  byte_t      head_byte;
  byte_t      tail_byte;

  // per-channel frame tracking
  logic [CNT_W-1:0] cnt_q  [CHANNELS];
  byte_t            sum_q  [CHANNELS];
  byte_t            prev_q [CHANNELS];
  byte_t            a1_q   [CHANNELS];
  byte_t            a2_q   [CHANNELS];
  byte_t            a3_q   [CHANNELS];

  // run in progress
  logic [CH_W-1:0]   em_ch;
  logic [ADDR_W-1:0] em_base;
  logic [CNT_W-1:0]  em_plen;
  logic [CNT_W-1:0]  em_k;
  byte_t             em_slave;
  byte_t             em_func;
  byte_t             em_err;
  byte_t             em_chk;

  logic out_valid;

  // ram signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  byte_t             ram_rdata;

  // per-byte decisions
  logic              accept;
  logic [CH_W-1:0]   ch_sel;
  logic [CNT_W-1:0]  p;
  byte_t             sum_c;
  byte_t             prev_c;
  logic              is_head;
  logic              is_tail;
  logic [CNT_W-1:0]  cnt_next;
  byte_t             sum_next;
  logic              store_data;
  logic              start_run;
  logic [ADDR_W-1:0] base;
  logic              chk_ok;
  logic              load;
  logic              last_k;

  assign accept  = bytes.valid && bytes.ready;
  assign ch_sel  = (int'(bytes.channel) < CHANNELS) ? CH_W'(bytes.channel) : '0;
  assign p       = cnt_q[ch_sel];
  assign sum_c   = sum_q[ch_sel];
  assign prev_c  = prev_q[ch_sel];
  assign is_head = (bytes.rx_byte == head_byte);
  assign is_tail = (bytes.rx_byte == tail_byte);
  assign base    = ADDR_W'(ch_sel) * ADDR_W'(BUFFER_BYTES);
  // checksum byte equals the sum of everything stored before it
  assign chk_ok  = (prev_c == 8'(sum_c - prev_c));

  // frame tracking decision for the byte on bytes
  always_comb begin
    cnt_next   = p;
    sum_next   = sum_c;
    ram_we     = 1'b0;
    store_data = 1'b0;
    start_run  = 1'b0;
    if (p == '0) begin
      if (is_head) begin
        ram_we   = 1'b1;
        cnt_next = CNT_W'(1);
        sum_next = bytes.rx_byte;
      end
    end else if (p >= CNT_W'(BUFFER_BYTES)) begin
      cnt_next = '0;
    end else begin
      ram_we = 1'b1;
      if (is_head && (p <= CNT_W'(MIN_FRAME - 1))) begin
        cnt_next = CNT_W'(1);
        sum_next = bytes.rx_byte;
      end else if (!is_head && is_tail) begin
        cnt_next  = '0;
        start_run = (p >= CNT_W'(MIN_FRAME - 1)) && chk_ok;
      end else begin
        cnt_next   = CNT_W'(p + CNT_W'(1));
        sum_next   = 8'(sum_c + bytes.rx_byte);
        store_data = 1'b1;
      end
    end
  end

  assign ram_waddr = base + ADDR_W'(p);
  assign ram_re    = (state == S_READ);
  assign ram_raddr = em_base + ADDR_W'(PAYLOAD_START) + ADDR_W'(em_k);

  fur_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we && accept),
    .waddr (ram_waddr),
    .wdata (bytes.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
      tail_byte <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD: head_byte <= cfg_data;
        REG_TAIL: tail_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (accept) begin
      cnt_q[ch_sel] <= cnt_next;
    end
  end

  // running sum, last byte and header capture
  always_ff @(posedge clk) begin
    if (accept && ram_we) begin
      sum_q[ch_sel]  <= sum_next;
      prev_q[ch_sel] <= bytes.rx_byte;
      if (store_data && (p == CNT_W'(1))) begin
        a1_q[ch_sel] <= bytes.rx_byte;
      end
      if (store_data && (p == CNT_W'(2))) begin
        a2_q[ch_sel] <= bytes.rx_byte;
      end
      if (store_data && (p == CNT_W'(3))) begin
        a3_q[ch_sel] <= bytes.rx_byte;
      end
    end
  end

  assign load   = (state == S_WAIT) && (!out_valid || frames.ready);
  assign last_k = (CNT_W'(em_k + CNT_W'(1)) == em_plen);

  // run sequencer: read one payload byte, then register it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && start_run) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_WAIT;
        S_WAIT: begin
          if (load) begin
            state <= last_k ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // run context
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && start_run) begin
      em_ch    <= ch_sel;
      em_base  <= base;
      em_plen  <= CNT_W'(p - CNT_W'(FRAME_OVERHEAD - 1));
      em_k     <= '0;
      em_slave <= a1_q[ch_sel];
      em_func  <= a2_q[ch_sel];
      em_err   <= a3_q[ch_sel];
      em_chk   <= prev_c;
    end else if (load) begin
      em_k <= CNT_W'(em_k + CNT_W'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (frames.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frames.out_channel    <= em_ch[0];
      frames.dev_addr       <= em_slave;
      frames.op_code        <= em_func;
      frames.status_code    <= em_err;
      frames.payload_len    <= len6_t'(em_plen);
      frames.byte_index     <= len6_t'(em_k);
      frames.payload_byte   <= ram_rdata;
      frames.frame_checksum <= em_chk;
      frames.last           <= last_k;
    end
  end

  assign frames.valid = out_valid;
  assign bytes.ready  = (state == S_IDLE);

  // checks on the run sequencer
  `FUR_ASSERT_NOW(a_run_index, state != S_IDLE, (em_k < em_plen), "run index out of range")
  `FUR_ASSERT_NEXT(a_read_then_wait, ram_re, state == S_WAIT, "read without data cycle")
  `FUR_ASSERT_NEXT(a_last_ends_run, load && last_k, state == S_IDLE, "run did not end")
  `FUR_ASSERT_NOW(a_valid_from_wait, $rose(out_valid), $past(state) == S_WAIT, "early result")

endmodule

>>> rtl/core/fur_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; read data holds while no read is issued
module fur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
